### hw/rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types, widths and constants of the vertex translate and project block.
// ----------------------------------------------------------------------------
package vtp_pkg;

   localparam int VTP_FRAC_BITS = 12;
   localparam int VTP_COORD_W   = 20;
   localparam int VTP_T_W       = VTP_COORD_W + 1;
   localparam int VTP_SCR_W     = 12;
   localparam int VTP_OUT_W     = 16;
   localparam int VTP_QUO_W     = VTP_OUT_W + 1;
   localparam int VTP_FOCAL     = 300;
   localparam int VTP_FOCAL_W   = 10;
   localparam int VTP_DATA_W    = 32;
   localparam int VTP_ADDR_W    = 5;

   localparam int VTP_POS_LIMIT = 2 ** (VTP_OUT_W - 1) - 1;
   localparam int VTP_NEG_LIMIT = 2 ** (VTP_OUT_W - 1);

   localparam logic [VTP_SCR_W-1:0] VTP_WIDTH_RESET  = 12'd800;
   localparam logic [VTP_SCR_W-1:0] VTP_HEIGHT_RESET = 12'd600;

   typedef enum logic [2:0] {
      VTP_REG_SHIFT_X       = 3'd0,
      VTP_REG_SHIFT_Y       = 3'd1,
      VTP_REG_SHIFT_Z       = 3'd2,
      VTP_REG_SCREEN_WIDTH  = 3'd3,
      VTP_REG_SCREEN_HEIGHT = 3'd4
   } vtp_reg_type;

   typedef struct packed {
      logic signed [VTP_COORD_W-1:0] shift_x;
      logic signed [VTP_COORD_W-1:0] shift_y;
      logic signed [VTP_COORD_W-1:0] shift_z;
      logic        [VTP_SCR_W-1:0]   screen_width;
      logic        [VTP_SCR_W-1:0]   screen_height;
   } vtp_cfg_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } vtp_ctl_type;

   function automatic int vtp_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int vtp_depth_w(input int frac_bits);
      return vtp_max(VTP_T_W, frac_bits + 3) + 1;
   endfunction

   function automatic int vtp_total_w(input int frac_bits);
      return vtp_max(VTP_T_W + VTP_FOCAL_W, VTP_SCR_W + vtp_depth_w(frac_bits)) + 1;
   endfunction

endpackage

### hw/rtl/vertex_translate_project.sv
// ----------------------------------------------------------------------------
// vertex_translate_project
// Translates a fixed-point vertex and projects it to saturated screen pixels.
//
//   Channel   Ports                                   Handshake
//   request   req_vertex_x/y/z                        start && !busy
//   response  rsp_pixel_x/y, rsp_clamped, rsp_zero_depth   rsp_strobe, one cycle
//   config    psel penable pwrite paddr pwdata prdata pready   APB write, no waits
//
// A vertex can be taken every cycle; busy is always low.
// Each result reaches the response ports through four arithmetic stages, a range
// check, 17 quotient stages of the divider and the output register, with the
// first stage loaded at the accepting edge.
// Reset empties the pipeline and loads the register defaults.
// The response side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module vertex_translate_project
   import vtp_pkg::*;
#(
   parameter int FRAC_BITS = VTP_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VTP_COORD_W-1:0] req_vertex_x,
   input  logic signed [VTP_COORD_W-1:0] req_vertex_y,
   input  logic signed [VTP_COORD_W-1:0] req_vertex_z,
   output logic                          rsp_strobe,
   output logic signed [VTP_OUT_W-1:0]   rsp_pixel_x,
   output logic signed [VTP_OUT_W-1:0]   rsp_pixel_y,
   output logic                          rsp_clamped,
   output logic                          rsp_zero_depth,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [VTP_ADDR_W-1:0]         paddr,
   input  logic [VTP_DATA_W-1:0]         pwdata,
   output logic [VTP_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int DEPTH_W = vtp_depth_w(FRAC_BITS);
   localparam int TOT_W   = vtp_total_w(FRAC_BITS);

   localparam logic [VTP_QUO_W-1:0] POS_LIM = VTP_QUO_W'(VTP_POS_LIMIT);
   localparam logic [VTP_QUO_W-1:0] NEG_LIM = VTP_QUO_W'(VTP_NEG_LIMIT);
   localparam logic [VTP_OUT_W-1:0] OUT_MAX = VTP_OUT_W'(VTP_POS_LIMIT);
   localparam logic [VTP_OUT_W-1:0] OUT_MIN = VTP_OUT_W'(VTP_NEG_LIMIT);

   vtp_cfg_type          cfg;
   logic                 in_valid;
   logic [TOT_W-1:0]     num_x, num_y;
   logic [DEPTH_W-1:0]   den;
   vtp_ctl_type          fr_ctl_x, fr_ctl_y;
   logic [VTP_QUO_W-1:0] quo_x, quo_y;
   logic                 ovf_x, ovf_y;
   vtp_ctl_type          ctl_x, ctl_y;

   logic [VTP_OUT_W:0]   sat_x, sat_y;
   logic                 strobe_in, strobe_ff;
   logic [VTP_OUT_W-1:0] pixel_x_in, pixel_x_ff;
   logic [VTP_OUT_W-1:0] pixel_y_in, pixel_y_ff;
   logic                 clamped_in, clamped_ff;
   logic                 zero_ff;

   function automatic logic [VTP_OUT_W:0] sat_axis(input logic [VTP_QUO_W-1:0] q,
                                                   input logic ovf_q,
                                                   input logic neg);
      logic                 sat;
      logic [VTP_OUT_W-1:0] val;
      if (!neg) begin
         sat = ovf_q || (q > POS_LIM);
         val = sat ? OUT_MAX : q[VTP_OUT_W-1:0];
      end else begin
         sat = ovf_q || (q > NEG_LIM);
         val = sat ? OUT_MIN : -q[VTP_OUT_W-1:0];
      end
      return {sat, val};
   endfunction

   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   vtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vtp_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .vertex_x (req_vertex_x),
      .vertex_y (req_vertex_y),
      .vertex_z (req_vertex_z),
      .cfg      (cfg),
      .num_x    (num_x),
      .num_y    (num_y),
      .den      (den),
      .ctl_x    (fr_ctl_x),
      .ctl_y    (fr_ctl_y)
   );

   vtp_div #(
      .NUM_W (TOT_W),
      .DEN_W (DEPTH_W),
      .QUO_W (VTP_QUO_W)
   ) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .num     (num_x),
      .den     (den),
      .ctl_in  (fr_ctl_x),
      .quo     (quo_x),
      .ovf     (ovf_x),
      .ctl_out (ctl_x)
   );

   vtp_div #(
      .NUM_W (TOT_W),
      .DEN_W (DEPTH_W),
      .QUO_W (VTP_QUO_W)
   ) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .num     (num_y),
      .den     (den),
      .ctl_in  (fr_ctl_y),
      .quo     (quo_y),
      .ovf     (ovf_y),
      .ctl_out (ctl_y)
   );

   always_comb begin
      sat_x     = sat_axis(quo_x, ovf_x, ctl_x.neg);
      sat_y     = sat_axis(quo_y, ovf_y, ctl_y.neg);
      strobe_in = ctl_y.valid;
      if (ctl_x.zero) begin
         pixel_x_in = '0;
         pixel_y_in = '0;
         clamped_in = 1'b0;
      end else begin
         pixel_x_in = sat_x[VTP_OUT_W-1:0];
         pixel_y_in = sat_y[VTP_OUT_W-1:0];
         clamped_in = sat_x[VTP_OUT_W] || sat_y[VTP_OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      clamped_ff <= clamped_in;
      zero_ff    <= ctl_x.zero;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_pixel_x    = $signed(pixel_x_ff);
   assign rsp_pixel_y    = $signed(pixel_y_ff);
   assign rsp_clamped    = clamped_ff;
   assign rsp_zero_depth = zero_ff;

   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      ctl_x.valid == ctl_y.valid)
      else $error("x and y divider lanes are out of step");

   a_zero_agrees : assert property (@(posedge clock) disable iff (reset)
      ctl_x.valid |-> ctl_x.zero == ctl_y.zero)
      else $error("x and y lanes disagree on zero depth");

   a_clamp_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_clamped
      |-> (pixel_x_ff == OUT_MAX) || (pixel_x_ff == OUT_MIN)
       || (pixel_y_ff == OUT_MAX) || (pixel_y_ff == OUT_MIN))
      else $error("clamped result has no coordinate at a limit");

endmodule

### hw/rtl/vtp_csr.sv
// ----------------------------------------------------------------------------
// vtp_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module vtp_csr
   import vtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [VTP_ADDR_W-1:0] paddr,
   input  logic [VTP_DATA_W-1:0] pwdata,
   output logic [VTP_DATA_W-1:0] prdata,
   output logic                  pready,
   output vtp_cfg_type           cfg
);

   logic signed [VTP_COORD_W-1:0] shift_x_ff;
   logic signed [VTP_COORD_W-1:0] shift_y_ff;
   logic signed [VTP_COORD_W-1:0] shift_z_ff;
   logic        [VTP_SCR_W-1:0]   width_ff;
   logic        [VTP_SCR_W-1:0]   height_ff;
   logic                          wr_en;
   vtp_reg_type                   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = vtp_reg_type'(paddr[VTP_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
         width_ff   <= VTP_WIDTH_RESET;
         height_ff  <= VTP_HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            VTP_REG_SHIFT_X:       shift_x_ff <= $signed(pwdata[VTP_COORD_W-1:0]);
            VTP_REG_SHIFT_Y:       shift_y_ff <= $signed(pwdata[VTP_COORD_W-1:0]);
            VTP_REG_SHIFT_Z:       shift_z_ff <= $signed(pwdata[VTP_COORD_W-1:0]);
            VTP_REG_SCREEN_WIDTH:  width_ff   <= pwdata[VTP_SCR_W-1:0];
            VTP_REG_SCREEN_HEIGHT: height_ff  <= pwdata[VTP_SCR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         VTP_REG_SHIFT_X:       prdata = VTP_DATA_W'($unsigned(shift_x_ff));
         VTP_REG_SHIFT_Y:       prdata = VTP_DATA_W'($unsigned(shift_y_ff));
         VTP_REG_SHIFT_Z:       prdata = VTP_DATA_W'($unsigned(shift_z_ff));
         VTP_REG_SCREEN_WIDTH:  prdata = VTP_DATA_W'(width_ff);
         VTP_REG_SCREEN_HEIGHT: prdata = VTP_DATA_W'(height_ff);
         default:               prdata = '0;
      endcase
   end

   assign cfg.shift_x       = shift_x_ff;
   assign cfg.shift_y       = shift_y_ff;
   assign cfg.shift_z       = shift_z_ff;
   assign cfg.screen_width  = width_ff;
   assign cfg.screen_height = height_ff;

   a_shift_z_write : assert property (@(posedge clock) disable iff (reset)
      wr_en && (reg_idx == VTP_REG_SHIFT_Z)
      |=> $unsigned(shift_z_ff) == $past(pwdata[VTP_COORD_W-1:0]))
      else $error("shift_z did not take the written value");

endmodule

### hw/rtl/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front
// Translation, depth, perspective numerators and magnitudes in four stages.
// ----------------------------------------------------------------------------
module vtp_front
   import vtp_pkg::*;
#(
   parameter int FRAC_BITS = VTP_FRAC_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic signed [VTP_COORD_W-1:0]            vertex_x,
   input  logic signed [VTP_COORD_W-1:0]            vertex_y,
   input  logic signed [VTP_COORD_W-1:0]            vertex_z,
   input  vtp_cfg_type                              cfg,
   output logic [vtp_total_w(FRAC_BITS)-1:0]        num_x,
   output logic [vtp_total_w(FRAC_BITS)-1:0]        num_y,
   output logic [vtp_depth_w(FRAC_BITS)-1:0]        den,
   output vtp_ctl_type                              ctl_x,
   output vtp_ctl_type                              ctl_y
);

   localparam int DEPTH_W = vtp_depth_w(FRAC_BITS);
   localparam int TOT_W   = vtp_total_w(FRAC_BITS);
   localparam int P_W     = VTP_T_W + VTP_FOCAL_W;
   localparam int C_W     = VTP_SCR_W + DEPTH_W;

   localparam logic signed [DEPTH_W-1:0]     DEPTH_BIAS = DEPTH_W'(1) << (FRAC_BITS + 2);
   localparam logic signed [VTP_FOCAL_W-1:0] FOCAL_POS  = VTP_FOCAL_W'(VTP_FOCAL);
   localparam logic signed [VTP_FOCAL_W-1:0] FOCAL_NEG  = VTP_FOCAL_W'(-VTP_FOCAL);

   logic signed [VTP_T_W-1:0]   f1_tx_in, f1_tx_ff;
   logic signed [VTP_T_W-1:0]   f1_ty_in, f1_ty_ff;
   logic signed [DEPTH_W-1:0]   f1_depth_in, f1_depth_ff;
   logic                        f1_valid_ff;

   logic signed [VTP_SCR_W-1:0] centre_x, centre_y;
   logic signed [P_W-1:0]       f2_ptx_in, f2_ptx_ff;
   logic signed [P_W-1:0]       f2_pty_in, f2_pty_ff;
   logic signed [C_W-1:0]       f2_pcx_in, f2_pcx_ff;
   logic signed [C_W-1:0]       f2_pcy_in, f2_pcy_ff;
   logic signed [DEPTH_W-1:0]   f2_depth_ff;
   logic                        f2_zero_ff;
   logic                        f2_valid_ff;

   logic signed [TOT_W-1:0]     f3_tot_x_in, f3_tot_x_ff;
   logic signed [TOT_W-1:0]     f3_tot_y_in, f3_tot_y_ff;
   logic [DEPTH_W-1:0]          f3_den_in, f3_den_ff;
   logic                        f3_dneg_ff;
   logic                        f3_zero_ff;
   logic                        f3_valid_ff;

   logic [TOT_W-1:0]            f4_num_x_in, f4_num_x_ff;
   logic [TOT_W-1:0]            f4_num_y_in, f4_num_y_ff;
   logic [DEPTH_W-1:0]          f4_den_ff;
   logic                        f4_neg_x_ff, f4_neg_y_ff;
   logic                        f4_zero_ff;
   logic                        f4_valid_ff;

   always_comb begin
      f1_tx_in    = VTP_T_W'(vertex_x) + VTP_T_W'(cfg.shift_x);
      f1_ty_in    = VTP_T_W'(vertex_y) + VTP_T_W'(cfg.shift_y);
      f1_depth_in = DEPTH_W'(vertex_z) + DEPTH_W'(cfg.shift_z) + DEPTH_BIAS;
   end

   always_comb begin
      centre_x  = $signed({1'b0, cfg.screen_width[VTP_SCR_W-1:1]});
      centre_y  = $signed({1'b0, cfg.screen_height[VTP_SCR_W-1:1]});
      f2_ptx_in = f1_tx_ff * FOCAL_POS;
      f2_pty_in = f1_ty_ff * FOCAL_NEG;
      f2_pcx_in = centre_x * f1_depth_ff;
      f2_pcy_in = centre_y * f1_depth_ff;
   end

   always_comb begin
      f3_tot_x_in = TOT_W'(f2_ptx_ff) + TOT_W'(f2_pcx_ff);
      f3_tot_y_in = TOT_W'(f2_pty_ff) + TOT_W'(f2_pcy_ff);
      f3_den_in   = f2_depth_ff[DEPTH_W-1] ? $unsigned(-f2_depth_ff) : $unsigned(f2_depth_ff);
   end

   always_comb begin
      f4_num_x_in = f3_tot_x_ff[TOT_W-1] ? $unsigned(-f3_tot_x_ff) : $unsigned(f3_tot_x_ff);
      f4_num_y_in = f3_tot_y_ff[TOT_W-1] ? $unsigned(-f3_tot_y_ff) : $unsigned(f3_tot_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
      f1_tx_ff    <= f1_tx_in;
      f1_ty_ff    <= f1_ty_in;
      f1_depth_ff <= f1_depth_in;

      f2_ptx_ff   <= f2_ptx_in;
      f2_pty_ff   <= f2_pty_in;
      f2_pcx_ff   <= f2_pcx_in;
      f2_pcy_ff   <= f2_pcy_in;
      f2_depth_ff <= f1_depth_ff;
      f2_zero_ff  <= (f1_depth_ff == '0);

      f3_tot_x_ff <= f3_tot_x_in;
      f3_tot_y_ff <= f3_tot_y_in;
      f3_den_ff   <= f3_den_in;
      f3_dneg_ff  <= f2_depth_ff[DEPTH_W-1];
      f3_zero_ff  <= f2_zero_ff;

      f4_num_x_ff <= f4_num_x_in;
      f4_num_y_ff <= f4_num_y_in;
      f4_den_ff   <= f3_den_ff;
      f4_neg_x_ff <= f3_tot_x_ff[TOT_W-1] ^ f3_dneg_ff;
      f4_neg_y_ff <= f3_tot_y_ff[TOT_W-1] ^ f3_dneg_ff;
      f4_zero_ff  <= f3_zero_ff;
   end

   assign num_x       = f4_num_x_ff;
   assign num_y       = f4_num_y_ff;
   assign den         = f4_den_ff;
   assign ctl_x.valid = f4_valid_ff;
   assign ctl_x.neg   = f4_neg_x_ff;
   assign ctl_x.zero  = f4_zero_ff;
   assign ctl_y.valid = f4_valid_ff;
   assign ctl_y.neg   = f4_neg_y_ff;
   assign ctl_y.zero  = f4_zero_ff;

endmodule

### hw/rtl/vtp_div.sv
// ----------------------------------------------------------------------------
// vtp_div
// Pipelined restoring divider, one quotient bit per stage, with range check.
// ----------------------------------------------------------------------------
module vtp_div
   import vtp_pkg::*;
#(
   parameter int NUM_W = 35,
   parameter int DEN_W = 22,
   parameter int QUO_W = VTP_QUO_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  vtp_ctl_type      ctl_in,
   output logic [QUO_W-1:0] quo,
   output logic             ovf,
   output vtp_ctl_type      ctl_out
);

   localparam int R_W = vtp_max(NUM_W, DEN_W + QUO_W);

   logic [NUM_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];
   vtp_ctl_type      ctl_ff [QUO_W+1];

   logic [NUM_W-1:0] rem_in [QUO_W+1];
   logic [QUO_W-1:0] quo_in [QUO_W+1];
   logic             ovf_in;

   assign ovf_in = R_W'(num) >= (R_W'(den) << QUO_W);

   always_comb begin
      logic [R_W-1:0] trial;
      logic           take;
      rem_in[0] = num;
      quo_in[0] = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         trial     = R_W'(den_ff[k-1]) << (QUO_W - k);
         take      = R_W'(rem_ff[k-1]) >= trial;
         rem_in[k] = take ? NUM_W'(R_W'(rem_ff[k-1]) - trial) : rem_ff[k-1];
         quo_in[k] = quo_ff[k-1];
         quo_in[k][QUO_W-k] = take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k <= QUO_W; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
      rem_ff[0] <= rem_in[0];
      den_ff[0] <= den;
      quo_ff[0] <= quo_in[0];
      ovf_ff[0] <= ovf_in;
      for (int k = 1; k <= QUO_W; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= quo_in[k];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign quo     = quo_ff[QUO_W];
   assign ovf     = ovf_ff[QUO_W];
   assign ctl_out = ctl_ff[QUO_W];

   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QUO_W].valid && !ovf_ff[QUO_W] && (den_ff[QUO_W] != '0)
      |-> rem_ff[QUO_W] < NUM_W'(den_ff[QUO_W]))
      else $error("final remainder is not below the divisor");

endmodule

### verif/tb_vertex_translate_project.sv
// ----------------------------------------------------------------------------
// tb_vertex_translate_project
// Self-checking testbench of the vertex translate and project block.
//
// A directed table of vertices runs first under the reset register values.
// Random vertices then follow under eight register settings, including the
// extremes. Each accepted transaction is predicted in the bench, and the
// prediction is queued until its result strobe arrives. Registers are written
// and read back over the APB port only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_vertex_translate_project
   import vtp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [VTP_OUT_W-1:0] px;
      logic signed [VTP_OUT_W-1:0] py;
      logic                        clamped;
      logic                        zero_depth;
   } pixel_type;

   typedef struct {
      logic signed [VTP_COORD_W-1:0] vx;
      logic signed [VTP_COORD_W-1:0] vy;
      logic signed [VTP_COORD_W-1:0] vz;
      bit                            typed;
      pixel_type                     result;
   } vertex_row_type;

   localparam pixel_type NO_RESULT = '0;
   localparam logic signed [VTP_COORD_W-1:0] COORD_MAX = 20'sd524287;
   localparam logic signed [VTP_COORD_W-1:0] COORD_MIN = -20'sd524288;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 138;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [VTP_COORD_W-1:0] req_vertex_x = '0;
   logic signed [VTP_COORD_W-1:0] req_vertex_y = '0;
   logic signed [VTP_COORD_W-1:0] req_vertex_z = '0;
   logic                          rsp_strobe;
   logic signed [VTP_OUT_W-1:0]   rsp_pixel_x;
   logic signed [VTP_OUT_W-1:0]   rsp_pixel_y;
   logic                          rsp_clamped;
   logic                          rsp_zero_depth;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [VTP_ADDR_W-1:0]         paddr = '0;
   logic [VTP_DATA_W-1:0]         pwdata = '0;
   logic [VTP_DATA_W-1:0]         prdata;
   logic                          pready;

   logic signed [VTP_COORD_W-1:0] cfg_shift_x = '0;
   logic signed [VTP_COORD_W-1:0] cfg_shift_y = '0;
   logic signed [VTP_COORD_W-1:0] cfg_shift_z = '0;
   logic [VTP_SCR_W-1:0]          cfg_width = VTP_WIDTH_RESET;
   logic [VTP_SCR_W-1:0]          cfg_height = VTP_HEIGHT_RESET;

   pixel_type expected_pixels[$];
   int        mismatches = 0;
   int        results_seen = 0;
   int        vertices_sent = 0;
   int        zero_depth_seen = 0;
   int        clamped_seen = 0;
   bit        sender_idles = 1'b1;

   vertex_row_type directed_rows [0:14] = '{
      '{20'sd0, 20'sd0, 20'sd0, 1'b1, '{16'sd400, 16'sd300, 1'b0, 1'b0}},
      '{20'sd0, 20'sd0, -20'sd16384, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
      '{COORD_MAX, COORD_MAX, -20'sd16383, 1'b1, '{16'sd32767, -16'sd32768, 1'b1, 1'b0}},
      '{COORD_MIN, COORD_MIN, -20'sd16383, 1'b1, '{-16'sd32768, 16'sd32767, 1'b1, 1'b0}},
      '{20'sd0, 20'sd0, -20'sd16385, 1'b1, '{16'sd400, 16'sd300, 1'b0, 1'b0}},
      '{20'sd4096, 20'sd4096, 20'sd0, 1'b1, '{16'sd475, 16'sd225, 1'b0, 1'b0}},
      '{20'sd1, -20'sd1, -20'sd16383, 1'b0, NO_RESULT},
      '{COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, NO_RESULT},
      '{COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, NO_RESULT},
      '{COORD_MAX, 20'sd0, -20'sd16385, 1'b0, NO_RESULT},
      '{-20'sd1, -20'sd1, -20'sd1, 1'b0, NO_RESULT},
      '{20'sd0, 20'sd0, COORD_MAX, 1'b0, NO_RESULT},
      '{20'sd0, 20'sd0, COORD_MIN, 1'b0, NO_RESULT},
      '{20'sd12345, -20'sd6789, 20'sd100000, 1'b0, NO_RESULT},
      '{-20'sd300000, 20'sd250000, -20'sd20000, 1'b0, NO_RESULT}
   };

   vertex_translate_project dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_vertex_x   (req_vertex_x),
      .req_vertex_y   (req_vertex_y),
      .req_vertex_z   (req_vertex_z),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_clamped    (rsp_clamped),
      .rsp_zero_depth (rsp_zero_depth),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [VTP_OUT_W-1:0] saturate16(input longint q,
                                                              inout logic sat);
      if (q > VTP_POS_LIMIT) begin
         sat = 1'b1;
         return VTP_OUT_W'(VTP_POS_LIMIT);
      end
      if (q < -longint'(VTP_NEG_LIMIT)) begin
         sat = 1'b1;
         return VTP_OUT_W'(VTP_NEG_LIMIT);
      end
      return q[VTP_OUT_W-1:0];
   endfunction

   function automatic pixel_type project_vertex(input logic signed [VTP_COORD_W-1:0] vx,
                                                input logic signed [VTP_COORD_W-1:0] vy,
                                                input logic signed [VTP_COORD_W-1:0] vz);
      longint    tx;
      longint    ty;
      longint    depth;
      longint    qx;
      longint    qy;
      logic      sat;
      pixel_type r;
      tx = longint'(vx) + longint'(cfg_shift_x);
      ty = longint'(vy) + longint'(cfg_shift_y);
      depth = longint'(vz) + longint'(cfg_shift_z) + (longint'(4) << VTP_FRAC_BITS);
      if (depth == 0) begin
         r = '{16'sd0, 16'sd0, 1'b0, 1'b1};
         return r;
      end
      qx = (tx * VTP_FOCAL + longint'(cfg_width >> 1) * depth) / depth;
      qy = (-ty * VTP_FOCAL + longint'(cfg_height >> 1) * depth) / depth;
      sat = 1'b0;
      r.px = saturate16(qx, sat);
      r.py = saturate16(qy, sat);
      r.clamped = sat;
      r.zero_depth = 1'b0;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s at result %0d: expected %0d, got %0d",
                  field, results_seen, want, got);
      end
   endtask

   task automatic enqueue_expected(input pixel_type entry);
      expected_pixels.insert(expected_pixels.size(), entry);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rsp_zero_depth) zero_depth_seen++;
         if (rsp_clamped) clamped_seen++;
         if (expected_pixels.size() == 0) begin
            note_mismatch("result with no transaction pending, pixel_x", 0,
                          longint'(rsp_pixel_x));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.px)
               note_mismatch("pixel_x", longint'(want.px), longint'(rsp_pixel_x));
            if (rsp_pixel_y !== want.py)
               note_mismatch("pixel_y", longint'(want.py), longint'(rsp_pixel_y));
            if (rsp_clamped !== want.clamped)
               note_mismatch("clamped", longint'(want.clamped), longint'(rsp_clamped));
            if (rsp_zero_depth !== want.zero_depth)
               note_mismatch("zero_depth", longint'(want.zero_depth),
                             longint'(rsp_zero_depth));
         end
      end
   end

   task automatic send_vertex(input logic signed [VTP_COORD_W-1:0] vx,
                              input logic signed [VTP_COORD_W-1:0] vy,
                              input logic signed [VTP_COORD_W-1:0] vz,
                              input bit typed, input pixel_type typed_result);
      while (sender_idles && $urandom_range(0, 99) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_vertex_z <= vz;
      do @(posedge clock); while (busy);
      enqueue_expected(typed ? typed_result : project_vertex(vx, vy, vz));
      vertices_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [VTP_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         VTP_REG_SHIFT_X:       cfg_shift_x = data[VTP_COORD_W-1:0];
         VTP_REG_SHIFT_Y:       cfg_shift_y = data[VTP_COORD_W-1:0];
         VTP_REG_SHIFT_Z:       cfg_shift_z = data[VTP_COORD_W-1:0];
         VTP_REG_SCREEN_WIDTH:  cfg_width = data[VTP_SCR_W-1:0];
         VTP_REG_SCREEN_HEIGHT: cfg_height = data[VTP_SCR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic read_reg(input logic [2:0] idx, output logic [VTP_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
   endtask

   task automatic verify_registers();
      logic [VTP_DATA_W-1:0] data;
      read_reg(VTP_REG_SHIFT_X, data);
      if (data[VTP_COORD_W-1:0] !== cfg_shift_x)
         note_mismatch("shift_x readback", longint'(cfg_shift_x),
                       longint'($signed(data[VTP_COORD_W-1:0])));
      read_reg(VTP_REG_SHIFT_Y, data);
      if (data[VTP_COORD_W-1:0] !== cfg_shift_y)
         note_mismatch("shift_y readback", longint'(cfg_shift_y),
                       longint'($signed(data[VTP_COORD_W-1:0])));
      read_reg(VTP_REG_SHIFT_Z, data);
      if (data[VTP_COORD_W-1:0] !== cfg_shift_z)
         note_mismatch("shift_z readback", longint'(cfg_shift_z),
                       longint'($signed(data[VTP_COORD_W-1:0])));
      read_reg(VTP_REG_SCREEN_WIDTH, data);
      if (data[VTP_SCR_W-1:0] !== cfg_width)
         note_mismatch("screen_width readback", longint'(cfg_width),
                       longint'(data[VTP_SCR_W-1:0]));
      read_reg(VTP_REG_SCREEN_HEIGHT, data);
      if (data[VTP_SCR_W-1:0] !== cfg_height)
         note_mismatch("screen_height readback", longint'(cfg_height),
                       longint'(data[VTP_SCR_W-1:0]));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VTP_DATA_W-1:0] random_shift();
      logic [VTP_DATA_W-1:0] data;
      data = $urandom();
      if ($urandom_range(0, 1) == 0)
         data[VTP_COORD_W-1:0] = VTP_COORD_W'(longint'($urandom_range(0, 32768)) - 16384);
      return data;
   endfunction

   task automatic program_phase(input int phase);
      logic [VTP_DATA_W-1:0] sx;
      logic [VTP_DATA_W-1:0] sy;
      logic [VTP_DATA_W-1:0] sz;
      logic [VTP_DATA_W-1:0] w;
      logic [VTP_DATA_W-1:0] h;
      case (phase)
         0: begin
            sx = 32'h0007_FFFF;
            sy = 32'h0007_FFFF;
            sz = 32'h0007_FFFF;
            w = 32'd4095;
            h = 32'd4095;
         end
         1: begin
            sx = 32'hFFF8_0000;
            sy = 32'hFFF8_0000;
            sz = 32'hFFF8_0000;
            w = 32'd1;
            h = 32'd0;
         end
         2: begin
            sx = 32'd0;
            sy = 32'd0;
            sz = 32'd0;
            w = 32'd0;
            h = 32'd1;
         end
         default: begin
            sx = random_shift();
            sy = random_shift();
            sz = random_shift();
            w = $urandom();
            h = $urandom();
         end
      endcase
      write_reg(VTP_REG_SHIFT_X, sx);
      write_reg(VTP_REG_SHIFT_Y, sy);
      write_reg(VTP_REG_SHIFT_Z, sz);
      write_reg(VTP_REG_SCREEN_WIDTH, w);
      write_reg(VTP_REG_SCREEN_HEIGHT, h);
      // Addresses past the last register must leave every register unchanged.
      if (phase == 2) begin
         write_reg(3'd5, $urandom());
         write_reg(3'd7, $urandom());
      end
      verify_registers();
   endtask

   function automatic logic signed [VTP_COORD_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return -20'sd1;
      endcase
   endfunction

   task automatic make_vertex(output logic signed [VTP_COORD_W-1:0] vx,
                              output logic signed [VTP_COORD_W-1:0] vy,
                              output logic signed [VTP_COORD_W-1:0] vz);
      int     mode;
      longint zz;
      mode = $urandom_range(0, 99);
      vx = VTP_COORD_W'($urandom());
      vy = VTP_COORD_W'($urandom());
      vz = VTP_COORD_W'($urandom());
      zz = -(longint'(4) << VTP_FRAC_BITS) - longint'(cfg_shift_z);
      if (mode < 25) begin
         // Depth at or near zero, where the quotient is large or undefined.
         if (mode >= 10) zz = zz + longint'($urandom_range(0, 128)) - 64;
         if (zz >= longint'(COORD_MIN) && zz <= longint'(COORD_MAX))
            vz = zz[VTP_COORD_W-1:0];
      end else if (mode < 40) begin
         vx = VTP_COORD_W'(longint'($urandom_range(0, 32768)) - 16384);
         vy = VTP_COORD_W'(longint'($urandom_range(0, 32768)) - 16384);
      end else if (mode < 50) begin
         vx = pick_extreme();
         vy = pick_extreme();
         vz = pick_extreme();
      end
   endtask

   initial begin
      logic signed [VTP_COORD_W-1:0] vx;
      logic signed [VTP_COORD_W-1:0] vy;
      logic signed [VTP_COORD_W-1:0] vz;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      verify_registers();
      foreach (directed_rows[i]) begin
         send_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].vz,
                     directed_rows[i].typed, directed_rows[i].result);
      end
      drain_results();
      for (int phase = 0; phase < PHASES; phase++) begin
         program_phase(phase);
         sender_idles = (phase != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
            make_vertex(vx, vy, vz);
            send_vertex(vx, vy, vz, 1'b0, NO_RESULT);
         end
         drain_results();
      end
      repeat (30) @(posedge clock);
      if (expected_pixels.size() != 0)
         note_mismatch("results still outstanding", 0, expected_pixels.size());
      $display("Run covered %0d vertex transactions under %0d register settings.",
               vertices_sent, PHASES + 1);
      $display("Results seen: %0d, of which %0d zero-depth and %0d clamped.",
               results_seen, zero_depth_seen, clamped_seen);
      if (mismatches == 0) begin
         $display("vertex_translate_project verification clean");
      end else begin
         $display("vertex_translate_project verification failed");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("vertex_translate_project verification failed");
      $finish;
   end

endmodule
